// ----- rtl/core/tsc_pkg.sv -----
package tsc_pkg;

   // field widths
   localparam int SAMPLE_W = 8;
   localparam int DZ_W     = 7;

   // conditioning constants
   localparam int AVG_DEPTH   = 10;
   localparam int CLAMP_LIMIT = 56;
   localparam int SCALE_TOP   = 127;
   localparam int DZ_RESET    = 10;

   // derived widths
   localparam int QMAG_MAX = SCALE_TOP / AVG_DEPTH;
   localparam int QMAG_W   = (QMAG_MAX > 0) ? $clog2(QMAG_MAX + 1) : 1;
   localparam int QUOT_W   = QMAG_W + 1;
   localparam int CLAMP_W  = $clog2(CLAMP_LIMIT + 1);
   localparam int SLOT_W   = (AVG_DEPTH > 1) ? $clog2(AVG_DEPTH) : 1;
   localparam int LUT_W    = (CLAMP_LIMIT + 1) * QMAG_W;

   // request and response payloads
   typedef struct packed {
      logic                       cmd;
      logic signed [SAMPLE_W-1:0] x_sample;
      logic signed [SAMPLE_W-1:0] y_sample;
      logic                       hold;
   } tsc_req_type;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] x_offset;
      logic signed [SAMPLE_W-1:0] y_offset;
   } tsc_rsp_type;

   // per-lane control from the sequencing logic
   typedef struct packed {
      logic load;
      logic update;
      logic capture;
   } tsc_lane_ctrl_type;

   // command codes
   localparam logic CMD_SAMPLE  = 1'b0;
   localparam logic CMD_CAPTURE = 1'b1;

   // clamped magnitude -> trunc(trunc(m * 127 / 56) / depth), packed table
   function automatic logic [LUT_W-1:0] build_quot_lut();
      logic [LUT_W-1:0] lut;
      lut = '0;
      for (int m = 0; m <= CLAMP_LIMIT; m++) begin
         lut[m*QMAG_W +: QMAG_W] = QMAG_W'(((m * SCALE_TOP) / CLAMP_LIMIT) / AVG_DEPTH);
      end
      return lut;
   endfunction

   localparam logic [LUT_W-1:0] QUOT_LUT = build_quot_lut();

   // clear lsb toward zero, subtract reference, saturate
   function automatic logic signed [SAMPLE_W-1:0] tsc_offset(
      input logic signed [SAMPLE_W-1:0] value,
      input logic signed [SAMPLE_W-1:0] refv
   );
      logic signed [SAMPLE_W-1:0] even;
      logic signed [SAMPLE_W:0]   diff;
      logic signed [SAMPLE_W-1:0] result;
      even = value;
      if (value[0]) begin
         even = value[SAMPLE_W-1] ? (value + SAMPLE_W'(1)) : (value - SAMPLE_W'(1));
      end
      diff = (SAMPLE_W+1)'(even) - (SAMPLE_W+1)'(refv);
      if (diff[SAMPLE_W] != diff[SAMPLE_W-1]) begin
         result = diff[SAMPLE_W] ? {1'b1, {(SAMPLE_W-1){1'b0}}} : {1'b0, {(SAMPLE_W-1){1'b1}}};
      end else begin
         result = diff[SAMPLE_W-1:0];
      end
      return result;
   endfunction

endpackage

// ----- rtl/core/tsc_lane.sv -----
module tsc_lane (
   input  logic                                clock,
   input  logic                                reset,
   input  logic [tsc_pkg::DZ_W-1:0]            dead_zone,
   input  logic signed [tsc_pkg::SAMPLE_W-1:0] sample,
   input  tsc_pkg::tsc_lane_ctrl_type          ctrl,
   input  logic [tsc_pkg::SLOT_W-1:0]          slot,
   output logic signed [tsc_pkg::SAMPLE_W-1:0] value_next,
   output logic signed [tsc_pkg::SAMPLE_W-1:0] reference
);
   import tsc_pkg::*;

   logic [SAMPLE_W-1:0]        mag;
   logic                       in_zone;
   logic [CLAMP_W-1:0]         clamp_mag;
   logic [QMAG_W-1:0]          q_mag;
   logic signed [QUOT_W-1:0]   q_in;
   logic signed [QUOT_W-1:0]   q_ff;
   logic signed [QUOT_W-1:0]   ring_ff [AVG_DEPTH];
   logic signed [SAMPLE_W-1:0] avg_ff;
   logic signed [SAMPLE_W-1:0] avg_in;
   logic signed [SAMPLE_W:0]   sum;
   logic signed [SAMPLE_W-1:0] ref_ff;

   // dead zone, clamp and rescale, kept as the quotient by the depth
   always_comb begin
      mag     = sample[SAMPLE_W-1] ? (~sample + 1'b1) : sample;
      in_zone = mag < SAMPLE_W'(dead_zone);
      if (in_zone) begin
         clamp_mag = '0;
      end else if (mag > SAMPLE_W'(CLAMP_LIMIT)) begin
         clamp_mag = CLAMP_W'(CLAMP_LIMIT);
      end else begin
         clamp_mag = mag[CLAMP_W-1:0];
      end
      q_mag = QUOT_LUT[clamp_mag*QMAG_W +: QMAG_W];
      q_in  = sample[SAMPLE_W-1] ? -$signed({1'b0, q_mag}) : $signed({1'b0, q_mag});
   end

   // running average: drop the oldest quotient, add the new one
   always_comb begin
      sum    = (SAMPLE_W+1)'(avg_ff) - (SAMPLE_W+1)'(ring_ff[slot]) + (SAMPLE_W+1)'(q_ff);
      avg_in = ctrl.update ? sum[SAMPLE_W-1:0] : avg_ff;
   end

   assign value_next = avg_in;
   assign reference  = ref_ff;

   // conditioned quotient register
   always_ff @(posedge clock) begin
      if (ctrl.load) begin
         q_ff <= q_in;
      end
   end

   // ring, average and reference
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < AVG_DEPTH; i++) begin
            ring_ff[i] <= '0;
         end
         avg_ff <= '0;
         ref_ff <= '0;
      end else begin
         if (ctrl.update) begin
            ring_ff[slot] <= q_ff;
            avg_ff        <= avg_in;
         end
         if (ctrl.capture) begin
            ref_ff <= avg_ff;
         end
      end
   end

`ifndef SYNTHESIS
   // capture takes the value left by all earlier samples
   a_capture_value: assert property (@(posedge clock) disable iff (reset)
      ctrl.capture |=> ref_ff == $past(avg_ff))
      else $error("reference does not match captured value");
`endif

endmodule

// ----- rtl/core/tsc_merge.sv -----
module tsc_merge (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                load,
   input  logic signed [tsc_pkg::SAMPLE_W-1:0] x_value,
   input  logic signed [tsc_pkg::SAMPLE_W-1:0] x_reference,
   input  logic signed [tsc_pkg::SAMPLE_W-1:0] y_value,
   input  logic signed [tsc_pkg::SAMPLE_W-1:0] y_reference,
   input  logic                                rsp_ready,
   output logic                                rsp_valid,
   output tsc_pkg::tsc_rsp_type                rsp_data
);
   import tsc_pkg::*;

   logic        valid_ff;
   logic        valid_in;
   tsc_rsp_type data_ff;
   tsc_rsp_type data_in;

   // combine both lanes into one response
   always_comb begin
      data_in.x_offset = tsc_offset(x_value, x_reference);
      data_in.y_offset = tsc_offset(y_value, y_reference);
      if (load) begin
         valid_in = 1'b1;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= data_in;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_data  = data_ff;

endmodule

// ----- rtl/core/tilt_sample_conditioner.sv -----
// tilt sample conditioner
// input channel req_*: one transaction per sample or capture command; cmd selects
// sample (conditions x and y) or capture (copies the current axis values into the
// references and returns nothing). hold on a sample leaves the averagers alone and
// still returns a response built from the held values.
// response channel rsp_*: one transaction per sample command, in request order,
// carrying x_offset and y_offset.
// csr_we / csr_wdata write the dead zone; write only while no transaction is
// in flight.
// a sample accepted into the input stage moves on into the response register, which
// drives rsp_valid. throughput: one transaction per cycle while responses are not
// stalled, limited by the ring and average update in each axis lane.
// a stalled response holds in the output register while one more request is
// taken into the input stage; a capture behind it still completes.
// reset (synchronous) clears the rings, averages, references and slot, empties
// both stages and sets the dead zone to 10.
module tilt_sample_conditioner (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  tsc_pkg::tsc_req_type        req_data,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output tsc_pkg::tsc_rsp_type        rsp_data,
   input  logic                        csr_we,
   input  logic [tsc_pkg::DZ_W-1:0]    csr_wdata
);
   import tsc_pkg::*;

   logic [DZ_W-1:0]            dead_zone_ff;
   logic                       s1_valid_ff;
   logic                       s1_valid_in;
   logic                       s1_cmd_ff;
   logic                       s1_hold_ff;
   logic [SLOT_W-1:0]          slot_ff;
   logic [SLOT_W-1:0]          slot_in;
   logic                       out_free;
   logic                       move;
   logic                       rsp_load;
   tsc_lane_ctrl_type          ctrl;
   logic signed [SAMPLE_W-1:0] x_value;
   logic signed [SAMPLE_W-1:0] x_reference;
   logic signed [SAMPLE_W-1:0] y_value;
   logic signed [SAMPLE_W-1:0] y_reference;

   // dead zone register
   always_ff @(posedge clock) begin
      if (reset) begin
         dead_zone_ff <= DZ_W'(DZ_RESET);
      end else if (csr_we) begin
         dead_zone_ff <= csr_wdata;
      end
   end

   // handshake and stage advance
   always_comb begin
      out_free     = !rsp_valid || rsp_ready;
      move         = s1_valid_ff && ((s1_cmd_ff == CMD_CAPTURE) || out_free);
      req_ready    = !s1_valid_ff || move;
      ctrl.load    = req_valid && req_ready;
      ctrl.update  = move && (s1_cmd_ff == CMD_SAMPLE) && !s1_hold_ff;
      ctrl.capture = move && (s1_cmd_ff == CMD_CAPTURE);
      rsp_load     = move && (s1_cmd_ff == CMD_SAMPLE);
      if (ctrl.load) begin
         s1_valid_in = 1'b1;
      end else if (move) begin
         s1_valid_in = 1'b0;
      end else begin
         s1_valid_in = s1_valid_ff;
      end
      if (!ctrl.update) begin
         slot_in = slot_ff;
      end else if (slot_ff == SLOT_W'(AVG_DEPTH - 1)) begin
         slot_in = '0;
      end else begin
         slot_in = slot_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         slot_ff     <= '0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         slot_ff     <= slot_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.load) begin
         s1_cmd_ff  <= req_data.cmd;
         s1_hold_ff <= req_data.hold;
      end
   end

   // one lane per axis
   tsc_lane u_lane_x (
      .clock      (clock),
      .reset      (reset),
      .dead_zone  (dead_zone_ff),
      .sample     (req_data.x_sample),
      .ctrl       (ctrl),
      .slot       (slot_ff),
      .value_next (x_value),
      .reference  (x_reference)
   );

   tsc_lane u_lane_y (
      .clock      (clock),
      .reset      (reset),
      .dead_zone  (dead_zone_ff),
      .sample     (req_data.y_sample),
      .ctrl       (ctrl),
      .slot       (slot_ff),
      .value_next (y_value),
      .reference  (y_reference)
   );

   // response register
   tsc_merge u_merge (
      .clock       (clock),
      .reset       (reset),
      .load        (rsp_load),
      .x_value     (x_value),
      .x_reference (x_reference),
      .y_value     (y_value),
      .y_reference (y_reference),
      .rsp_ready   (rsp_ready),
      .rsp_valid   (rsp_valid),
      .rsp_data    (rsp_data)
   );

`ifndef SYNTHESIS
   // a stalled sample stays in the input stage
   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && (s1_cmd_ff == CMD_SAMPLE) && !out_free |=> s1_valid_ff)
      else $error("stalled sample left the input stage");

   // hold leaves the ring slot alone
   a_hold_slot: assert property (@(posedge clock) disable iff (reset)
      move && (s1_cmd_ff == CMD_SAMPLE) && s1_hold_ff |=> $stable(slot_ff))
      else $error("slot moved on a held sample");

   // slot advances on every real update
   a_slot_step: assert property (@(posedge clock) disable iff (reset)
      ctrl.update |=> slot_ff != $past(slot_ff))
      else $error("slot did not advance");

   // a response only ever comes from a sample command
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(rsp_load))
      else $error("response without a sample");
`endif

endmodule

// ----- bench/tilt_sample_conditioner_tb.sv -----
module tilt_sample_conditioner_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import tsc_pkg::*;

   // one backlog entry: a request transaction, or a pause until all responses are back
   typedef struct packed {
      logic        drain;
      tsc_req_type req;
   } backlog_entry_type;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_ready;
   tsc_req_type       req_data = '0;
   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   tsc_rsp_type       rsp_data;
   logic              csr_we = 1'b0;
   logic [DZ_W-1:0]   csr_wdata = DZ_W'(DZ_RESET);

   backlog_entry_type req_backlog[$];
   backlog_entry_type next_entry;
   tsc_rsp_type       pending_offsets[$];
   tsc_rsp_type       oldest_offsets;
   int                results_pending = 0;
   int                errors = 0;
   int                sender_idle_pct = 0;
   int                receiver_stall_pct = 0;

   // conditioning state mirrored from the block
   logic [DZ_W-1:0]           dead_zone_setting = DZ_W'(DZ_RESET);
   logic signed [SAMPLE_W-1:0] x_window[AVG_DEPTH] = '{default: '0};
   logic signed [SAMPLE_W-1:0] y_window[AVG_DEPTH] = '{default: '0};
   logic [SLOT_W-1:0]          window_pos = '0;
   logic signed [SAMPLE_W-1:0] x_mean = '0;
   logic signed [SAMPLE_W-1:0] y_mean = '0;
   logic signed [SAMPLE_W-1:0] x_level = '0;
   logic signed [SAMPLE_W-1:0] y_level = '0;
   logic signed [SAMPLE_W-1:0] x_zero = '0;
   logic signed [SAMPLE_W-1:0] y_zero = '0;

   tilt_sample_conditioner u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   // dead zone, clamp and rescale of one raw reading
   function automatic int rescale_reading(logic signed [SAMPLE_W-1:0] raw);
      int v;
      int lim;
      v = raw;
      lim = dead_zone_setting;
      if (v > -lim && v < lim) begin
         v = 0;
      end
      if (v < -CLAMP_LIMIT) begin
         v = -CLAMP_LIMIT;
      end else if (v > CLAMP_LIMIT) begin
         v = CLAMP_LIMIT;
      end
      return (v * SCALE_TOP) / CLAMP_LIMIT;
   endfunction

   // clear lsb toward zero, subtract the reference, saturate to 8 bits
   function automatic logic signed [SAMPLE_W-1:0] tilt_offset(
      logic signed [SAMPLE_W-1:0] level,
      logic signed [SAMPLE_W-1:0] zero
   );
      int d;
      d = (int'(level) / 2) * 2 - int'(zero);
      if (d < -128) begin
         d = -128;
      end else if (d > 127) begin
         d = 127;
      end
      return d[SAMPLE_W-1:0];
   endfunction

   // advance the averagers for one accepted sample and queue its response, or take a capture's reference
   task automatic predict_offsets(input tsc_req_type t);
      int xr;
      int yr;
      int xa;
      int ya;
      tsc_rsp_type r;
      if (t.cmd == CMD_CAPTURE) begin
         x_zero = x_level;
         y_zero = y_level;
         return;
      end
      if (!t.hold) begin
         xr = rescale_reading(t.x_sample);
         yr = rescale_reading(t.y_sample);
         xa = int'(x_mean) - int'(x_window[window_pos]) / AVG_DEPTH + xr / AVG_DEPTH;
         ya = int'(y_mean) - int'(y_window[window_pos]) / AVG_DEPTH + yr / AVG_DEPTH;
         x_window[window_pos] = xr[SAMPLE_W-1:0];
         y_window[window_pos] = yr[SAMPLE_W-1:0];
         x_mean = xa[SAMPLE_W-1:0];
         y_mean = ya[SAMPLE_W-1:0];
         x_level = x_mean;
         y_level = y_mean;
         window_pos = (window_pos == SLOT_W'(AVG_DEPTH - 1)) ? '0 : window_pos + 1'b1;
      end
      r.x_offset = tilt_offset(x_level, x_zero);
      r.y_offset = tilt_offset(y_level, y_zero);
      pending_offsets.push_back(r);
   endtask

   task automatic queue_request(logic cmd, logic [SAMPLE_W-1:0] x, logic [SAMPLE_W-1:0] y,
                                logic hold);
      backlog_entry_type e;
      e.drain = 1'b0;
      e.req.cmd = cmd;
      e.req.x_sample = x;
      e.req.y_sample = y;
      e.req.hold = hold;
      req_backlog.push_back(e);
   endtask

   task automatic queue_drain();
      backlog_entry_type e;
      e = '0;
      e.drain = 1'b1;
      req_backlog.push_back(e);
   endtask

   // readings biased toward the dead zone edge, the clamp edge and the extremes
   function automatic logic [SAMPLE_W-1:0] pick_reading();
      int d;
      d = dead_zone_setting;
      case ($urandom_range(9))
         0: return SAMPLE_W'(d - 1 + $urandom_range(1));
         1: return SAMPLE_W'(-d + $urandom_range(1));
         2: return SAMPLE_W'(CLAMP_LIMIT + $urandom_range(1));
         3: return SAMPLE_W'(-CLAMP_LIMIT - $urandom_range(1));
         4: return $urandom_range(1) ? 8'h7f : 8'h80;
         default: return SAMPLE_W'($urandom_range(255));
      endcase
   endfunction

   task automatic queue_random_requests(int count);
      int r;
      for (int i = 0; i < count; i++) begin
         r = $urandom_range(99);
         if (r < 2) begin
            queue_drain();
         end
         if (r < 8) begin
            queue_request(CMD_CAPTURE, SAMPLE_W'($urandom_range(255)),
                          SAMPLE_W'($urandom_range(255)), 1'($urandom_range(1)));
         end else begin
            queue_request(CMD_SAMPLE, pick_reading(), pick_reading(),
                          $urandom_range(9) == 0);
         end
      end
   endtask

   // wait until the backlog is empty and every response is back, plus a margin
   task automatic wait_idle();
      do begin
         @(negedge clock);
      end while (req_backlog.size() != 0 || req_valid || results_pending != 0);
      repeat (4) @(negedge clock);
   endtask

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_ready) begin
         if (req_backlog.size() > 0 && req_backlog[0].drain) begin
            if (!req_valid && results_pending == 0) begin
               void'(req_backlog.pop_front());
            end
            req_valid <= 1'b0;
         end else if (req_backlog.size() > 0 && $urandom_range(99) >= sender_idle_pct) begin
            next_entry = req_backlog.pop_front();
            req_valid <= 1'b1;
            req_data <= next_entry.req;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // response monitor and scoreboard
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= receiver_stall_pct);
         if (rsp_valid && rsp_ready) begin
            if (pending_offsets.size() == 0) begin
               $display("%0t unexpected response x_offset %0d y_offset %0d",
                        $time, rsp_data.x_offset, rsp_data.y_offset);
               errors++;
            end else begin
               oldest_offsets = pending_offsets.pop_front();
               if (rsp_data.x_offset !== oldest_offsets.x_offset) begin
                  $display("%0t x_offset mismatch: expected %0d actual %0d",
                           $time, oldest_offsets.x_offset, rsp_data.x_offset);
                  errors++;
               end
               if (rsp_data.y_offset !== oldest_offsets.y_offset) begin
                  $display("%0t y_offset mismatch: expected %0d actual %0d",
                           $time, oldest_offsets.y_offset, rsp_data.y_offset);
                  errors++;
               end
            end
         end
         if (req_valid && req_ready) begin
            predict_offsets(req_data);
         end
      end
      results_pending <= pending_offsets.size();
   end

   // stimulus sequence
   initial begin
      int dz;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // directed: dead zone and clamp edges at the reset dead zone
      sender_idle_pct = 24;
      receiver_stall_pct = 80;
      queue_request(CMD_SAMPLE, 8'sd9, -8'sd9, 1'b0);
      queue_request(CMD_SAMPLE, 8'sd10, -8'sd10, 1'b0);
      queue_request(CMD_SAMPLE, 8'sd57, -8'sd57, 1'b0);
      // fill both windows with opposite extremes, then capture that as reference
      for (int i = 0; i < AVG_DEPTH; i++) begin
         queue_request(CMD_SAMPLE, 8'h80, 8'h7f, 1'b0);
      end
      queue_request(CMD_CAPTURE, 8'h00, 8'h00, 1'b0);
      queue_drain();
      // swing to the other extremes so both offsets saturate
      for (int i = 0; i < AVG_DEPTH; i++) begin
         queue_request(CMD_SAMPLE, 8'h7f, 8'h80, 1'b0);
      end
      // hold keeps the averagers; capture ignores its payload
      queue_request(CMD_SAMPLE, 8'h05, 8'hfb, 1'b1);
      queue_request(CMD_CAPTURE, 8'h80, 8'h7f, 1'b1);
      queue_request(CMD_SAMPLE, 8'h00, 8'h00, 1'b1);
      wait_idle();

      // random phases, each with its own dead zone; each pair of phases shares an idle pattern
      for (int phase = 0; phase < 6; phase++) begin
         case (phase)
            0: dz = 0;
            1: dz = 127;
            3: dz = DZ_RESET;
            default: dz = $urandom_range(127);
         endcase
         @(posedge clock);
         csr_we <= 1'b1;
         csr_wdata <= DZ_W'(dz);
         @(posedge clock);
         csr_we <= 1'b0;
         dead_zone_setting = DZ_W'(dz);
         case (phase / 2)
            0: begin
               sender_idle_pct = 24;
               receiver_stall_pct = 80;
            end
            1: begin
               sender_idle_pct = 80;
               receiver_stall_pct = 24;
            end
            default: begin
               sender_idle_pct = 0;
               receiver_stall_pct = 0;
            end
         endcase
         queue_random_requests(340);
         wait_idle();
      end

      if (errors == 0 && pending_offsets.size() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

   // run limit
   initial begin
      #2_000_000;
      $display("simulation failed");
      $finish;
   end

endmodule
